[sv/poly_trajectory_player_defines.svh]
// Assertion macros shared by the checker of the trajectory player.
// Depends on nothing; expects clk and arst_n in the scope of each use.
`ifndef POLY_TRAJECTORY_PLAYER_DEFINES_SVH
`define POLY_TRAJECTORY_PLAYER_DEFINES_SVH

// Condition a implies condition c in the same cycle.
`define PTP_ASSERT_NOW(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);

// Condition a implies condition c in the following cycle.
`define PTP_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);

`endif

[sv/ptp_pkg.sv]
// Package of the polynomial trajectory player: codes, states and defaults.
// Used by the top level and by its checker; depends on nothing.
package ptp_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int NUM_COEFFS_DEF  = 10;
	localparam int AXES            = 3;
	localparam int NUM_HELD        = 9;
	localparam int VAL_W           = 64;
	localparam int TIME_W          = 32;
	localparam int IN_DATA_W       = 136;
	localparam int OUT_DATA_W      = NUM_HELD * VAL_W;

	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_COPY,
		S_CFIN,
		S_RD,
		S_MH,
		S_ML,
		S_MT,
		S_SUM,
		S_NEXT,
		S_EMIT
	} state_t;

endpackage

[sv/ptp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ptp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/poly_trajectory_player.sv]
// Polynomial trajectory player: segment queue and Horner evaluator.
// Depends on ptp_pkg and ptp_ram.
//
// Input beats arrive on s_tvalid/s_tready; s_tuser carries the command
// (load coefficient, push segment, tick, clear). Results leave on
// m_tvalid/m_tready: the nine held values in m_tdata, active and rejected
// in m_tuser. Loads, clears and zero-duration pushes give no result.
// A load or a clear leaves s_tready high. A push copies the staged set of
// 3*NUM_COEFFS coefficients into the segment memory, one word a cycle,
// so s_tready is low through S_COPY and S_CFIN. A refused push or
// a tick with no segment to evaluate gives its result through S_EMIT and
// the output register. A tick on a live segment runs every Horner step
// through one shared 32x32 multiplier and one saturating adder, each step
// passing S_RD, S_MH, S_ML, S_MT and S_SUM: 3*(3*NUM_COEFFS-3) steps, plus
// one S_NEXT write-back per held value; s_tready is low until S_EMIT ends.
// The result sits in an output register; if the receiver stalls, the
// block holds the beat and waits before it loads the next one.
// Reset empties the queue, clears the held outputs and makes the staged set
// read as zero; the segment memory needs no clearing pass.
module poly_trajectory_player
	import ptp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int NUM_COEFFS  = NUM_COEFFS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// axis[1:0], power[5:2], coefficient[69:6], duration[101:70],
	// time_now[133:102], zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// cmd[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pos_x, vel_x, acc_x, pos_y, vel_y, acc_y, pos_z, vel_z, acc_z,
	// 64 bits each from the lowest bit up
	output logic [OUT_DATA_W-1:0] m_tdata,
	// active[0], rejected[1]
	output logic [1:0]            m_tuser
);

	localparam int SN  = AXES * NUM_COEFFS;
	localparam int SAW = $clog2(SN);
	localparam int CN  = QUEUE_DEPTH * SN;
	localparam int CAW = $clog2(CN);
	localparam int QW  = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);

	// Input fields.
	logic [1:0]        in_axis;
	logic [3:0]        in_power;
	logic [VAL_W-1:0]  in_coef;
	logic [TIME_W-1:0] in_dur;
	logic [TIME_W-1:0] in_now;
	cmd_t              in_cmd;

	assign in_axis  = s_tdata[1:0];
	assign in_power = s_tdata[5:2];
	assign in_coef  = s_tdata[69:6];
	assign in_dur   = s_tdata[101:70];
	assign in_now   = s_tdata[133:102];
	assign in_cmd   = cmd_t'(s_tuser);

	state_t state_q, state_d;

	logic [QW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [TIME_W-1:0] start_q;
	logic [QW-1:0]     slot_q;
	logic [SAW-1:0]    cnt_q;
	logic [TIME_W-1:0] dur_q [QUEUE_DEPTH];
	logic [TIME_W-1:0] cap_dur_q;
	logic [TIME_W-1:0] t_q;
	logic [1:0]        axis_q;
	logic [1:0]        d_q;
	logic [3:0]        i_q;
	logic [VAL_W-1:0]  acc_q;
	logic              neg_q;
	logic [VAL_W-1:0]  mag_q;
	logic [63:0]       hi_q;
	logic [63:0]       lo_q;
	logic [VAL_W-1:0]  mt_q;
	logic [VAL_W-1:0]  scl_q;
	logic [VAL_W-1:0]  held_q [NUM_HELD];
	logic              active_q;
	logic              rej_q;
	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [1:0]        out_user_q;
	logic [SN-1:0]     stg_vld_q;
	logic              stg_hit_q;

	// Memory ports.
	logic              stg_we;
	logic [SAW-1:0]    stg_waddr;
	logic [SAW-1:0]    stg_raddr;
	logic [VAL_W-1:0]  stg_rdata;
	logic              coef_we;
	logic [CAW-1:0]    coef_waddr;
	logic [CAW-1:0]    coef_raddr;
	logic [VAL_W-1:0]  coef_rdata;
	logic [VAL_W-1:0]  coef_wdata;
	logic              out_load;

	ptp_ram #(.WIDTH(VAL_W), .DEPTH(SN)) u_stage_ram (
		.clk   (clk),
		.we    (stg_we),
		.waddr (stg_waddr),
		.wdata (in_coef),
		.raddr (stg_raddr),
		.rdata (stg_rdata)
	);

	// Staged words not loaded since reset are copied as zero.
	assign coef_wdata = stg_hit_q ? stg_rdata : '0;

	ptp_ram #(.WIDTH(VAL_W), .DEPTH(CN)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	logic accept;
	assign accept = s_tvalid && s_tready;

	// Queue bookkeeping on a push or a tick.
	logic [TIME_W-1:0] elapsed;
	logic              retire;
	logic              q_full;
	logic [QW:0]       tail_sum;
	logic [QW-1:0]     tail;
	logic [QW-1:0]     head_inc;

	assign elapsed  = in_now - start_q;
	assign retire   = (count_q != '0) && (elapsed >= dur_q[head_q]);
	assign q_full   = count_q >= CW'(QUEUE_DEPTH);
	assign tail_sum = (QW+1)'(head_q) + (QW+1)'(count_q);
	assign tail     = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
		QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
	assign head_inc = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	logic last_step;
	logic last_run;
	assign last_step = (i_q == {2'b00, d_q});
	assign last_run  = (axis_q == 2'd2) && (d_q == 2'd2);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (in_cmd)
						CMD_PUSH: begin
							if (in_dur == '0) begin
								state_d = S_IDLE;
							end else if (q_full) begin
								state_d = S_EMIT;
							end else begin
								state_d = S_COPY;
							end
						end
						CMD_TICK: begin
							if (count_q == '0 || (retire && count_q == CW'(1))) begin
								state_d = S_EMIT;
							end else begin
								state_d = S_RD;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_COPY: if (cnt_q == SAW'(SN - 1)) state_d = S_CFIN;
			S_CFIN: state_d = S_IDLE;
			S_RD:   state_d = (i_q < {2'b00, d_q}) ? S_NEXT : S_MH;
			S_MH:   state_d = S_ML;
			S_ML:   state_d = S_MT;
			S_MT:   state_d = S_SUM;
			S_SUM:  state_d = last_step ? S_NEXT : S_RD;
			S_NEXT: state_d = last_run ? S_EMIT : S_RD;
			S_EMIT: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		s_tready   = (state_q == S_IDLE);
		stg_we     = accept && (in_cmd == CMD_LOAD) && (in_axis < 2'(AXES)) &&
			({1'b0, in_power} < 5'(NUM_COEFFS));
		stg_waddr  = SAW'(in_axis) * SAW'(NUM_COEFFS) + SAW'(in_power);
		stg_raddr  = cnt_q;
		coef_we    = (state_q == S_CFIN) || (state_q == S_COPY && cnt_q != '0);
		coef_waddr = CAW'(slot_q) * CAW'(SN) +
			((state_q == S_CFIN) ? CAW'(cnt_q) : CAW'(cnt_q) - 1'b1);
		coef_raddr = CAW'(head_q) * CAW'(SN) + CAW'(axis_q) * CAW'(NUM_COEFFS) +
			CAW'(i_q);
		out_load   = (state_q == S_EMIT) && (!m_tvalid_q || m_tready);
	end

	// Shared multiplier: high then low half of the accumulator magnitude.
	logic [31:0] mul_a;
	logic [63:0] mul_p;
	assign mul_a = (state_q == S_MH) ? mag_q[63:32] : mag_q[31:0];
	assign mul_p = mul_a * t_q;

	// Coefficient scaled by 1, i or i*(i-1), saturated.
	logic [7:0]         k;
	logic signed [72:0] sprod;
	logic [VAL_W-1:0]   scl_d;
	always_comb begin
		unique case (d_q)
			2'd1:    k = {4'b0000, i_q};
			2'd2:    k = 8'(i_q) * (8'(i_q) - 8'd1);
			default: k = 8'd1;
		endcase
		sprod = $signed(coef_rdata) * $signed({1'b0, k});
		if (sprod[72:63] != {10{sprod[63]}}) begin
			scl_d = sprod[72] ? VAL_MIN : VAL_MAX;
		end else begin
			scl_d = sprod[63:0];
		end
	end

	// Product recombination: floor of acc*t/2^16, saturated.
	logic [63:0]      q_mag;
	logic [63:0]      q_neg;
	logic             hi_ovf;
	logic [VAL_W-1:0] mt_d;
	always_comb begin
		hi_ovf = |hi_q[63:47];
		q_mag  = {hi_q[47:0], 16'h0000} + {16'h0000, lo_q[63:16]};
		q_neg  = q_mag + {63'd0, |lo_q[15:0]};
		if (neg_q) begin
			mt_d = (hi_ovf || q_neg[63]) ? VAL_MIN : (64'd0 - q_neg);
		end else begin
			mt_d = (hi_ovf || q_mag[63]) ? VAL_MAX : q_mag;
		end
	end

	logic [64:0]      sum;
	logic [VAL_W-1:0] sum_sat;
	assign sum     = {mt_q[63], mt_q} + {scl_q[63], scl_q};
	assign sum_sat = (sum[64] != sum[63]) ? (sum[64] ? VAL_MIN : VAL_MAX) : sum[63:0];

	logic [3:0] held_idx;
	assign held_idx = 4'(axis_q) * 4'd3 + 4'(d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			start_q    <= '0;
			m_tvalid_q <= 1'b0;
			stg_vld_q  <= '0;
			for (int j = 0; j < NUM_HELD; j++) begin
				held_q[j] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (stg_we) begin
				stg_vld_q[stg_waddr] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (accept) begin
				unique case (in_cmd)
					CMD_PUSH: begin
						if (in_dur != '0 && !q_full && count_q == '0) begin
							start_q <= in_now;
						end
					end
					CMD_TICK: begin
						if (retire) begin
							start_q <= in_now;
							head_q  <= head_inc;
							count_q <= count_q - 1'b1;
						end
					end
					CMD_CLEAR: begin
						count_q <= '0;
						head_q  <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == S_CFIN) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_NEXT) begin
				held_q[held_idx] <= acc_q;
			end
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		stg_hit_q <= stg_vld_q[stg_raddr];
		if (accept) begin
			cap_dur_q <= in_dur;
			slot_q    <= tail;
			cnt_q     <= '0;
			t_q       <= retire ? '0 : elapsed;
			axis_q    <= 2'd0;
			d_q       <= 2'd0;
			i_q       <= 4'(NUM_COEFFS - 1);
			acc_q     <= '0;
			active_q  <= (in_cmd == CMD_TICK) && (count_q != '0) &&
				!(retire && count_q == CW'(1));
			rej_q     <= (in_cmd == CMD_PUSH) && q_full;
		end
		unique case (state_q)
			S_COPY: if (cnt_q != SAW'(SN - 1)) cnt_q <= cnt_q + 1'b1;
			S_CFIN: dur_q[slot_q] <= cap_dur_q;
			S_RD: begin
				neg_q <= acc_q[63];
				mag_q <= acc_q[63] ? (64'd0 - acc_q) : acc_q;
			end
			S_MH: begin
				hi_q  <= mul_p;
				scl_q <= scl_d;
			end
			S_ML:  lo_q <= mul_p;
			S_MT:  mt_q <= mt_d;
			S_SUM: begin
				acc_q <= sum_sat;
				if (!last_step) i_q <= i_q - 1'b1;
			end
			S_NEXT: begin
				acc_q <= '0;
				i_q   <= 4'(NUM_COEFFS - 1);
				if (d_q == 2'd2) begin
					d_q    <= 2'd0;
					axis_q <= axis_q + 1'b1;
				end else begin
					d_q <= d_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			for (int j = 0; j < NUM_HELD; j++) begin
				out_data_q[j*VAL_W +: VAL_W] <= held_q[j];
			end
			out_user_q <= {rej_q, active_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

[sv/ptp_checker.sv]
// Port-level checker for the trajectory player, bound to the top level.
// Depends on ptp_pkg and poly_trajectory_player_defines.svh.
`include "poly_trajectory_player_defines.svh"

module ptp_checker
	import ptp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [1:0]            s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]            m_tuser
);

	`PTP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
	`PTP_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
	`PTP_ASSERT_NOW(a_flags, m_tvalid, !(m_tuser[0] && m_tuser[1]), "result both active and rejected")
	`PTP_ASSERT_NEXT(a_tick_busy, s_tvalid && s_tready && s_tuser == CMD_TICK, !s_tready, "tick did not occupy the block")

endmodule

bind poly_trajectory_player ptp_checker u_ptp_checker (.*);
